// ===== src/ucfd_pkg.sv =====
// Shared constants and types for the UART CAN frame deframer.
// No dependencies; used by ucfd_collect and uart_can_frame_deframer.
`default_nettype none

package ucfd_pkg;

    localparam int POS_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int ID_W    = 32;
    localparam int PLD_W   = 64;
    localparam int STAT_W  = 2;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_byte FRAME_FLAG = 8'h7e;

    // byte positions within a 17-byte frame
    localparam t_pos POS_HUNT      = 5'd0;
    localparam t_pos POS_FIRST     = 5'd1;
    localparam t_pos XOR_START     = 5'd2;
    localparam t_pos ID_FIRST      = 5'd3;
    localparam t_pos PLD_FIRST     = 5'd7;
    localparam t_pos CKSUM_POS     = 5'd15;
    localparam t_pos END_POS       = 5'd16;

    localparam int ID_BYTES  = ID_W / BYTE_W;
    localparam int PLD_BYTES = PLD_W / BYTE_W;

    typedef enum logic [STAT_W-1:0] {
        ST_GOOD      = 2'd0,
        ST_CKSUM_ERR = 2'd1,
        ST_END_ERR   = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PLD_W-1:0]  payload;
        logic [STAT_W-1:0] status;
    } t_frame_result;

endpackage

`default_nettype wire

// ===== src/ucfd_collect.sv =====
// Frame collector: byte position, running XOR, id/payload assembly, checks.
// Depends on ucfd_pkg.
`default_nettype none

module ucfd_collect (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire ucfd_pkg::t_byte       i_byte,
    output logic                       o_res_valid,
    output ucfd_pkg::t_frame_result    o_res
);

    ucfd_pkg::t_pos              r_pos,    n_pos;
    ucfd_pkg::t_byte             r_xor,    n_xor;
    ucfd_pkg::t_byte             r_cksum,  n_cksum;
    logic [ucfd_pkg::ID_W-1:0]   r_id,     n_id;
    logic [ucfd_pkg::PLD_W-1:0]  r_pld,    n_pld;
    logic                        w_done;
    ucfd_pkg::t_status           w_status;

    always_comb begin
        n_pos   = r_pos;
        n_xor   = r_xor;
        n_cksum = r_cksum;
        n_id    = r_id;
        n_pld   = r_pld;
        w_done  = 1'b0;
        if (r_pos == ucfd_pkg::POS_HUNT) begin
            if (i_byte == ucfd_pkg::FRAME_FLAG) begin
                n_xor   = '0;
                n_cksum = '0;
                n_id    = '0;
                n_pld   = '0;
                n_pos   = ucfd_pkg::POS_FIRST;
            end
        end else if (r_pos > ucfd_pkg::END_POS) begin
            n_pos = ucfd_pkg::POS_HUNT;
        end else if (r_pos < ucfd_pkg::CKSUM_POS) begin
            if (r_pos >= ucfd_pkg::XOR_START) begin
                n_xor = r_xor ^ i_byte;
            end
            for (int k = 0; k < ucfd_pkg::ID_BYTES; k++) begin
                if (r_pos == ucfd_pkg::t_pos'(int'(ucfd_pkg::ID_FIRST) + k)) begin
                    n_id[k*ucfd_pkg::BYTE_W +: ucfd_pkg::BYTE_W] =
                        r_id[k*ucfd_pkg::BYTE_W +: ucfd_pkg::BYTE_W] | i_byte;
                end
            end
            for (int k = 0; k < ucfd_pkg::PLD_BYTES; k++) begin
                if (r_pos == ucfd_pkg::t_pos'(int'(ucfd_pkg::PLD_FIRST) + k)) begin
                    n_pld[k*ucfd_pkg::BYTE_W +: ucfd_pkg::BYTE_W] =
                        r_pld[k*ucfd_pkg::BYTE_W +: ucfd_pkg::BYTE_W] | i_byte;
                end
            end
            n_pos = r_pos + ucfd_pkg::t_pos'(1);
        end else if (r_pos == ucfd_pkg::CKSUM_POS) begin
            n_cksum = i_byte;
            n_pos   = r_pos + ucfd_pkg::t_pos'(1);
        end else begin
            // end marker byte: frame complete, good or bad
            w_done = 1'b1;
            n_pos  = ucfd_pkg::POS_HUNT;
        end
    end

    // end-marker fault takes priority over checksum fault
    always_comb begin
        if (i_byte != ucfd_pkg::FRAME_FLAG) begin
            w_status = ucfd_pkg::ST_END_ERR;
        end else if (r_xor != r_cksum) begin
            w_status = ucfd_pkg::ST_CKSUM_ERR;
        end else begin
            w_status = ucfd_pkg::ST_GOOD;
        end
    end

    assign o_res_valid    = i_step && w_done;
    assign o_res.id       = r_id;
    assign o_res.payload  = r_pld;
    assign o_res.status   = w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= ucfd_pkg::POS_HUNT;
        end else if (i_step) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_xor   <= n_xor;
            r_cksum <= n_cksum;
            r_id    <= n_id;
            r_pld   <= n_pld;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= ucfd_pkg::END_POS)
        else $error("byte position out of frame range");

    a_done_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> r_pos == ucfd_pkg::POS_HUNT)
        else $error("no return to hunting after frame end");

    a_drop_noise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_pos == ucfd_pkg::POS_HUNT && i_byte != ucfd_pkg::FRAME_FLAG)
        |=> r_pos == ucfd_pkg::POS_HUNT)
        else $error("non-flag byte started a frame");

    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_pos != ucfd_pkg::POS_HUNT && r_pos < ucfd_pkg::END_POS)
        |=> r_pos == $past(r_pos) + ucfd_pkg::t_pos'(1))
        else $error("frame byte did not advance position");
`endif

endmodule

`default_nettype wire

// ===== src/uart_can_frame_deframer.sv =====
// Top level of the UART CAN frame deframer: input register, collector, result register.
// Depends on ucfd_pkg and ucfd_collect.
//
// Usage:
//   Input channel: i_rx_valid / o_rx_ready carry one received byte (i_rx_byte) per transfer.
//   Output channel: o_frame_valid / i_frame_ready carry one result per 17-byte frame:
//   o_frame_id, o_frame_payload, o_frame_status (0 good, 1 checksum error, 2 bad end marker).
//   A frame starts at a 0x7e byte; other bytes seen while hunting are dropped.
//   Throughput: one byte per cycle sustained while no result waits on a low i_frame_ready;
//   each byte is processed by the collector between the input and result registers.
//   Path: the result for a frame is presented from the result register, which takes it
//   from the collector once its 17th byte has passed through the input register.
//   Stall: while a result waits in the result register and i_frame_ready is low, the
//   pipeline holds; the input register still takes one byte if it is empty.
//   Reset (i_rst_n low, synchronous): both registers empty, collector hunting for a
//   start byte.
`default_nettype none

module uart_can_frame_deframer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rx_valid,
    output logic                               o_rx_ready,
    input  wire logic [ucfd_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                               o_frame_valid,
    input  wire logic                          i_frame_ready,
    output logic [ucfd_pkg::ID_W-1:0]          o_frame_id,
    output logic [ucfd_pkg::PLD_W-1:0]         o_frame_payload,
    output logic [ucfd_pkg::STAT_W-1:0]        o_frame_status
);

    logic                       r_in_valid;
    ucfd_pkg::t_byte            r_in_byte;
    logic                       r_out_valid;
    ucfd_pkg::t_frame_result    r_out;
    logic                       w_adv;
    logic                       w_step;
    logic                       w_res_valid;
    ucfd_pkg::t_frame_result    w_res;

    assign w_adv      = !r_out_valid || i_frame_ready;
    assign w_step     = r_in_valid && w_adv;
    assign o_rx_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    ucfd_collect u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_frame_valid   = r_out_valid;
    assign o_frame_id      = r_out.id;
    assign o_frame_payload = r_out.payload;
    assign o_frame_status  = r_out.status;

endmodule

`default_nettype wire
